// File: rtl/best_fit_free_list_allocator_assert.svh
// Assertion macros shared by the allocator's checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Clocked property check, off while reset is asserted
`define BFFLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check, off while reset is asserted
`define BFFLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/bffla_pkg.sv
// Package for the best-fit free-list allocator: field widths, codes, types.
// No dependencies.
package bffla_pkg;

    localparam int MEMORY_WORDS = 1024;
    localparam int ADDR_W       = $clog2(MEMORY_WORDS);
    localparam int SIZE_W       = ADDR_W + 1;
    localparam int CMD_W        = 2;
    localparam int STAT_W       = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = ADDR_W'(64);
    localparam logic [SIZE_W-1:0] POOL_SIZE_RST = SIZE_W'(MEMORY_WORDS - 64);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_RELOAD = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RSVD  = 2'd3
    } stat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BASE = 1'b0,
        REG_POOL_SIZE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } entry_t;

endpackage

// File: rtl/best_fit_free_list_allocator.sv
// Best-fit free-list allocator: top level with the free-block table memory.
// Depends on bffla_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, req_size, block_address.
//   Output channel (out_valid/out_ready) returns status, granted_address and
//   free_entries, one result per input transfer, in order.
//   Configuration: cfg_we with cfg_index 0 (pool_base) or 1 (pool_size).
// Flow:
//   Free, reload and the unused code go from the transfer straight to the
//   result state. Allocate reads the table once through the single read
//   port of the table memory, one entry per cycle. An exact fit then moves
//   each later entry down one place, one per cycle.
//   One item is in work at a time; the next is taken once its result is in
//   the output register.
// Reset:
//   The first cycle after reset writes the default pool into entry 0; no
//   input is taken in that cycle.
// Stall:
//   A result waits in the output register while out_ready is low; the block
//   takes the next item meanwhile but holds its result until the register
//   frees.
module best_fit_free_list_allocator
    import bffla_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic [SIZE_W-1:0]    req_size,
    input  logic [ADDR_W-1:0]    block_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STAT_W-1:0]    status,
    output logic [ADDR_W-1:0]    granted_address,
    output logic [CNT_W-1:0]     free_entries,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Table memory
    entry_t mem_array [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    // Control and working registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    entry_t            best_reg, best_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    stat_t             res_stat_reg, res_stat_next;
    logic [ADDR_W-1:0] res_gnt_reg, res_gnt_next;
    logic [ADDR_W-1:0] pool_base_reg;
    logic [SIZE_W-1:0] pool_size_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [ADDR_W-1:0] out_gnt_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic out_free;
    logic in_xfer;
    logic scan_more;
    logic fits;
    entry_t pool_entry;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign scan_more  = (cnt_reg < count_reg);
    assign fits       = (rd_data_reg.size >= size_reg) &&
                        (!found_reg || (rd_data_reg.size < best_reg.size));
    assign pool_entry = '{size: pool_size_reg, start: pool_base_reg};

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_array[mem_raddr];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RST;
            pool_size_reg <= POOL_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_BASE: pool_base_reg <= cfg_data[ADDR_W-1:0];
                REG_POOL_SIZE: pool_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:  state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((cmd_t'(command) == CMD_ALLOC) && (count_reg != '0))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                if (!scan_more && !pend_reg)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (found_reg && (best_reg.size == size_reg))
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (!scan_more && !pend_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        res_stat_next = res_stat_reg;
        res_gnt_next  = res_gnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = pool_entry;
        mem_re        = 1'b0;
        mem_raddr     = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            // Place the default pool into entry 0
            S_INIT:
            begin
                mem_we     = 1'b1;
                count_next = CNT_W'(1);
            end
            // Take an item; finish the single-cycle commands at once
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next      = command;
                    size_next     = req_size;
                    addr_next     = block_address;
                    res_stat_next = STAT_OK;
                    res_gnt_next  = '0;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    case (cmd_t'(command))
                        CMD_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                res_stat_next = STAT_NOFIT;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (count_reg >= DEPTH_CNT)
                            begin
                                res_stat_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = '{size: req_size, start: block_address};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_RELOAD:
                        begin
                            mem_we     = 1'b1;
                            count_next = CNT_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            // Read each entry once; keep the smallest one that fits
            S_SCAN:
            begin
                if (scan_more)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                if (pend_reg && fits)
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_next     = rd_data_reg;
                end
            end
            // Shrink the winner, or start the shift-down for an exact fit
            S_APPLY:
            begin
                if (!found_reg)
                begin
                    res_stat_next = STAT_NOFIT;
                end
                else
                begin
                    res_gnt_next = best_reg.start;
                    // Sum truncated to the address width wraps modulo MEMORY_WORDS
                    if (best_reg.size > size_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = best_idx_reg;
                        mem_wdata = '{size:  best_reg.size - size_reg,
                                      start: best_reg.start + size_reg[ADDR_W-1:0]};
                    end
                    else
                    begin
                        cnt_next = CNT_W'(best_idx_reg) + CNT_W'(1);
                    end
                end
            end
            // Move each later entry down one place
            S_SHIFT:
            begin
                if (scan_more)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = IDX_W'(cnt_reg - CNT_W'(1));
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_idx_reg;
                    mem_wdata = rd_data_reg;
                end
                if (!scan_more && !pend_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_RESP: ;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CNT_W'(1);
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            // Hold the result until the transfer, load a new one when free
            if ((state_reg == S_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        res_stat_reg <= res_stat_next;
        res_gnt_reg  <= res_gnt_next;
        if ((state_reg == S_RESP) && out_free)
        begin
            out_stat_reg <= res_stat_reg;
            out_gnt_reg  <= res_gnt_reg;
            out_cnt_reg  <= count_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_stat_reg;
    assign granted_address = out_gnt_reg;
    assign free_entries    = out_cnt_reg;

endmodule

// File: rtl/bffla_checker.sv
// Port-level checker for the best-fit free-list allocator, bound to the top.
// Depends on bffla_pkg and best_fit_free_list_allocator_assert.svh.
`include "best_fit_free_list_allocator_assert.svh"

module bffla_checker
    import bffla_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [STAT_W-1:0]    status,
    input logic [ADDR_W-1:0]    granted_address,
    input logic [CNT_W-1:0]     free_entries
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // No address is granted unless the allocate succeeded
    `BFFLA_ASSERT_IMP(a_gnt_zero, out_valid && (status != STAT_OK), granted_address == '0, "grant on failure")
    // Table full is only reported with a full table
    `BFFLA_ASSERT_IMP(a_full_cnt, out_valid && (status == STAT_FULL), free_entries == DEPTH_CNT, "full with room")
    // Entry count never exceeds the table depth
    `BFFLA_ASSERT_IMP(a_cnt_max, out_valid, free_entries <= DEPTH_CNT, "count above depth")
    // A stalled result holds its status
    `BFFLA_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(status)), "result dropped")

endmodule

bind best_fit_free_list_allocator bffla_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_bffla_checker (.*);
